/* design/rvc_exp_pkg.sv */
// ----------------------------------------------------------------------------
// rvc_exp_pkg
// Opcodes, decode classes and encoding builders for the RV32C expander.
// ----------------------------------------------------------------------------
`default_nettype none

package rvc_exp_pkg;

	// Major opcodes of the 32-bit encodings
	localparam logic [6:0] OP_IMM  = 7'b0010011;
	localparam logic [6:0] OP_JAL  = 7'b1101111;
	localparam logic [6:0] OP_BR   = 7'b1100011;
	localparam logic [6:0] OP_ST   = 7'b0100011;
	localparam logic [6:0] OP_LD   = 7'b0000011;
	localparam logic [6:0] OP_REG  = 7'b0110011;
	localparam logic [6:0] OP_JALR = 7'b1100111;
	localparam logic [6:0] OP_LUI  = 7'b0110111;
	localparam logic [6:0] OP_FLD  = 7'b0000111;
	localparam logic [6:0] OP_FST  = 7'b0100111;

	localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
	localparam logic [31:0] SRA_FLAG    = 32'h4000_0000;

	// Fixed register numbers
	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_RA   = 5'd1;
	localparam logic [4:0] REG_SP   = 5'd2;

	// funct3 codes used by the expansions
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SRL  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;

	localparam logic [6:0] F7_ZERO = 7'h00;
	localparam logic [6:0] F7_SUB  = 7'h20;

	// Quadrant codes (bits 1:0 of the halfword)
	localparam logic [1:0] QUAD0 = 2'b00;
	localparam logic [1:0] QUAD1 = 2'b01;
	localparam logic [1:0] QUAD2 = 2'b10;
	localparam logic [1:0] QUAD_FULL = 2'b11;

	// Decoded instruction class carried between decode and assembly
	typedef enum logic [4:0] {
		CLS_PASS,
		CLS_ILL,
		CLS_ADDI4SPN,
		CLS_LW,
		CLS_FLW,
		CLS_SW,
		CLS_FSW,
		CLS_ADDI,
		CLS_JAL,
		CLS_LI,
		CLS_ADDI16SP,
		CLS_LUI,
		CLS_SRLI,
		CLS_SRAI,
		CLS_ANDI,
		CLS_SUB,
		CLS_XOR,
		CLS_OR,
		CLS_AND,
		CLS_J,
		CLS_BEQZ,
		CLS_BNEZ,
		CLS_SLLI,
		CLS_LWSP,
		CLS_JR,
		CLS_JALR,
		CLS_EBREAK,
		CLS_MV,
		CLS_ADD,
		CLS_SWSP
	} cls_t;

	function automatic logic [31:0] mk_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
		logic [4:0] rd, logic [6:0] op);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] mk_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] mk_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3, logic [6:0] op);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
	endfunction

	// imm is a 21-bit byte offset, bit 0 always zero
	function automatic logic [31:0] mk_j(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
	endfunction

	// imm is a 13-bit byte offset, bit 0 always zero; rs2 is x0
	function automatic logic [31:0] mk_b(logic [12:0] imm, logic [4:0] rs1, logic [2:0] f3);
		return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OP_BR};
	endfunction

endpackage

`default_nettype wire

/* design/rvc_instruction_expander.sv */
// ----------------------------------------------------------------------------
// rvc_instruction_expander
// Three-stage pipelined RV32C (plus C.FLW/C.FSW) to RV32I/F expander.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive fetch_word and raise start; an item is taken at
//   every rising edge with start high and busy low. busy is always low, so
//   a new item may enter every cycle.
//   Output channel: done is high for exactly one cycle per item, with
//   expanded_instr, is_compressed and illegal valid in that cycle.
//   Pipeline: an accepted item passes through three register stages,
//   capture, class decode and word assembly, in that order, before it
//   shows on the outputs. Throughput: one item per cycle.
//   The receiver cannot stall; results are produced in order, one per item.
//   Reset clears all valid bits; items in flight are dropped. The block
//   keeps no other state.
//   Full 32-bit words (bits 1:0 = 11) pass through unchanged; illegal
//   compressed encodings give a zero word with illegal set.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_instruction_expander (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] fetch_word,
	output logic             done,
	output logic [31:0]      expanded_instr,
	output logic             is_compressed,
	output logic             illegal
);
	import rvc_exp_pkg::*;

	// Stage registers
	logic        valid_s1, valid_s2, valid_s3;
	logic [31:0] word_s1, word_s2;
	cls_t        cls_s2;
	logic [31:0] expanded_instr_s3;
	logic        is_compressed_s3;
	logic        illegal_s3;

	// Never hold the sender off: every stage advances each cycle
	assign busy = 1'b0;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: capture the fetch word
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			word_s1 <= fetch_word;
		end
	end

	// Stage 2: decode the instruction class and legality
	logic [15:0] h1;
	logic [4:0]  rd1;
	logic [4:0]  rs2_1;
	cls_t        cls_d;

	assign h1    = word_s1[15:0];
	assign rd1   = h1[11:7];
	assign rs2_1 = h1[6:2];

	always_comb begin
		cls_d = CLS_ILL;
		unique case (h1[1:0])
			QUAD0: begin
				case (h1[15:13])
					3'd0: cls_d = (h1[12:5] == 8'd0) ? CLS_ILL : CLS_ADDI4SPN;
					3'd2: cls_d = CLS_LW;
					3'd3: cls_d = CLS_FLW;
					3'd6: cls_d = CLS_SW;
					3'd7: cls_d = CLS_FSW;
					default: cls_d = CLS_ILL;
				endcase
			end
			QUAD1: begin
				case (h1[15:13])
					3'd0: cls_d = CLS_ADDI;
					3'd1: cls_d = CLS_JAL;
					3'd2: cls_d = (rd1 == REG_ZERO) ? CLS_ILL : CLS_LI;
					3'd3: begin
						if (rd1 == REG_SP) begin
							cls_d = ({h1[12], h1[6:2]} == 6'd0) ? CLS_ILL : CLS_ADDI16SP;
						end else if (rd1 == REG_ZERO || {h1[12], h1[6:2]} == 6'd0) begin
							cls_d = CLS_ILL;
						end else begin
							cls_d = CLS_LUI;
						end
					end
					3'd4: begin
						case (h1[11:10])
							2'd0: cls_d = CLS_SRLI;
							2'd1: cls_d = CLS_SRAI;
							2'd2: cls_d = CLS_ANDI;
							default: begin
								case (h1[6:5])
									2'd0: cls_d = CLS_SUB;
									2'd1: cls_d = CLS_XOR;
									2'd2: cls_d = CLS_OR;
									default: cls_d = CLS_AND;
								endcase
							end
						endcase
					end
					3'd5: cls_d = CLS_J;
					3'd6: cls_d = CLS_BEQZ;
					default: cls_d = CLS_BNEZ;
				endcase
			end
			QUAD2: begin
				case (h1[15:13])
					3'd0: cls_d = (rd1 == REG_ZERO) ? CLS_ILL : CLS_SLLI;
					3'd2: cls_d = (rd1 == REG_ZERO) ? CLS_ILL : CLS_LWSP;
					3'd4: begin
						if (rs2_1 == REG_ZERO) begin
							if (!h1[12]) begin
								cls_d = (rd1 == REG_ZERO) ? CLS_ILL : CLS_JR;
							end else begin
								cls_d = (rd1 == REG_ZERO) ? CLS_EBREAK : CLS_JALR;
							end
						end else if (rd1 == REG_ZERO) begin
							cls_d = CLS_ILL;
						end else begin
							cls_d = h1[12] ? CLS_ADD : CLS_MV;
						end
					end
					3'd6: cls_d = CLS_SWSP;
					default: cls_d = CLS_ILL;
				endcase
			end
			QUAD_FULL: cls_d = CLS_PASS;
			default: cls_d = CLS_ILL;
		endcase
	end

	always_ff @(posedge clk) begin
		word_s2 <= word_s1;
		cls_s2  <= cls_d;
	end

	// Stage 3: assemble the 32-bit encoding
	logic [15:0] h2;
	logic [4:0]  rd2, rdp2, r1p2, rs2_2;
	logic [11:0] sx6, uimm6, wimm, a4spn, a16sp, lwsp, swsp;
	logic [20:0] jimm;
	logic [12:0] bimm;
	logic [19:0] lui_imm;
	logic [31:0] asm_d;

	assign h2    = word_s2[15:0];
	assign rd2   = h2[11:7];
	assign rs2_2 = h2[6:2];
	assign rdp2  = {2'b01, h2[4:2]};
	assign r1p2  = {2'b01, h2[9:7]};

	assign sx6     = {{6{h2[12]}}, h2[12], h2[6:2]};
	assign uimm6   = {6'd0, h2[12], h2[6:2]};
	assign wimm    = {5'd0, h2[5], h2[12:10], h2[6], 2'b00};
	assign a4spn   = {2'b00, h2[10:7], h2[12:11], h2[5], h2[6], 2'b00};
	assign a16sp   = {{3{h2[12]}}, h2[4:3], h2[5], h2[2], h2[6], 4'd0};
	assign lwsp    = {4'd0, h2[3:2], h2[12], h2[6:4], 2'b00};
	assign swsp    = {4'd0, h2[8:7], h2[12:9], 2'b00};
	assign lui_imm = {{14{h2[12]}}, h2[12], h2[6:2]};
	assign jimm    = {{9{h2[12]}}, h2[12], h2[8], h2[10:9], h2[6], h2[7], h2[2], h2[11],
		h2[5:3], 1'b0};
	assign bimm    = {{5{h2[12]}}, h2[6:5], h2[2], h2[11:10], h2[4:3], 1'b0};

	always_comb begin
		asm_d = 32'd0;
		unique case (cls_s2)
			CLS_PASS:     asm_d = word_s2;
			CLS_ILL:      asm_d = 32'd0;
			CLS_ADDI4SPN: asm_d = mk_i(a4spn, REG_SP, F3_ADD, rdp2, OP_IMM);
			CLS_LW:       asm_d = mk_i(wimm, r1p2, F3_WORD, rdp2, OP_LD);
			CLS_FLW:      asm_d = mk_i(wimm, r1p2, F3_WORD, rdp2, OP_FLD);
			CLS_SW:       asm_d = mk_s(wimm, rdp2, r1p2, F3_WORD, OP_ST);
			CLS_FSW:      asm_d = mk_s(wimm, rdp2, r1p2, F3_WORD, OP_FST);
			CLS_ADDI:     asm_d = mk_i(sx6, rd2, F3_ADD, rd2, OP_IMM);
			CLS_JAL:      asm_d = mk_j(jimm, REG_RA);
			CLS_LI:       asm_d = mk_i(sx6, REG_ZERO, F3_ADD, rd2, OP_IMM);
			CLS_ADDI16SP: asm_d = mk_i(a16sp, REG_SP, F3_ADD, REG_SP, OP_IMM);
			CLS_LUI:      asm_d = {lui_imm, rd2, OP_LUI};
			CLS_SRLI:     asm_d = mk_i(uimm6, r1p2, F3_SRL, r1p2, OP_IMM);
			CLS_SRAI:     asm_d = mk_i(uimm6, r1p2, F3_SRL, r1p2, OP_IMM) | SRA_FLAG;
			CLS_ANDI:     asm_d = mk_i(sx6, r1p2, F3_AND, r1p2, OP_IMM);
			CLS_SUB:      asm_d = mk_r(F7_SUB, rdp2, r1p2, F3_ADD, r1p2, OP_REG);
			CLS_XOR:      asm_d = mk_r(F7_ZERO, rdp2, r1p2, F3_XOR, r1p2, OP_REG);
			CLS_OR:       asm_d = mk_r(F7_ZERO, rdp2, r1p2, F3_OR, r1p2, OP_REG);
			CLS_AND:      asm_d = mk_r(F7_ZERO, rdp2, r1p2, F3_AND, r1p2, OP_REG);
			CLS_J:        asm_d = mk_j(jimm, REG_ZERO);
			CLS_BEQZ:     asm_d = mk_b(bimm, r1p2, F3_BEQ);
			CLS_BNEZ:     asm_d = mk_b(bimm, r1p2, F3_BNE);
			CLS_SLLI:     asm_d = mk_i(uimm6, rd2, F3_SLL, rd2, OP_IMM);
			CLS_LWSP:     asm_d = mk_i(lwsp, REG_SP, F3_WORD, rd2, OP_LD);
			CLS_JR:       asm_d = mk_i(12'd0, rd2, F3_ADD, REG_ZERO, OP_JALR);
			CLS_JALR:     asm_d = mk_i(12'd0, rd2, F3_ADD, REG_RA, OP_JALR);
			CLS_EBREAK:   asm_d = EBREAK_WORD;
			CLS_MV:       asm_d = mk_r(F7_ZERO, rs2_2, REG_ZERO, F3_ADD, rd2, OP_REG);
			CLS_ADD:      asm_d = mk_r(F7_ZERO, rs2_2, rd2, F3_ADD, rd2, OP_REG);
			CLS_SWSP:     asm_d = mk_s(swsp, rs2_2, REG_SP, F3_WORD, OP_ST);
			default:      asm_d = 32'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		expanded_instr_s3 <= asm_d;
		is_compressed_s3  <= (cls_s2 != CLS_PASS);
		illegal_s3        <= (cls_s2 == CLS_ILL);
	end

	// Drive the result ports
	assign done           = valid_s3;
	assign expanded_instr = expanded_instr_s3;
	assign is_compressed  = is_compressed_s3;
	assign illegal        = illegal_s3;

	// Every accepted item comes out as a result strobe on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted item did not produce a result after three cycles");

	// No result without a matching accepted item
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result strobe without a matching accepted item");

	// Illegal results carry a zero word and are always compressed
	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && illegal) |-> (expanded_instr == 32'd0 && is_compressed))
		else $error("illegal result with nonzero word or full-width flag");

	// Pass-through words keep their full-width quadrant code
	a_pass_quad: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_compressed) |-> (expanded_instr[1:0] == QUAD_FULL && !illegal))
		else $error("full-width result with wrong quadrant or illegal flag");

	// Legal expansions are always full-width encodings
	a_expand_quad: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_compressed && !illegal) |-> (expanded_instr[1:0] == QUAD_FULL))
		else $error("expanded word is not a 32-bit encoding");

endmodule

`default_nettype wire
